@@ design/ttfw_pkg.sv @@
// shared types, constants and functions for the tilt to four-way controls block
package ttfw_pkg;

  localparam int unsigned TimeBits  = 48;
  localparam int unsigned AngFrac   = 7;
  localparam int unsigned CordSteps = 16;
  localparam int unsigned TabFrac   = 16;
  // cordic working width: inputs scaled by 256 plus growth
  localparam int unsigned CW        = 28;
  localparam int unsigned ZW        = 26;
  localparam logic signed [15:0] HalfTurn = 16'sd23040;

  localparam logic [TimeBits-1:0] CoinUs  = TimeBits'(100000);
  localparam logic [TimeBits-1:0] GapUs   = TimeBits'(500000);
  localparam logic [TimeBits-1:0] StartUs = TimeBits'(600000);

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_INV_ROLL  = 3'd1,
    REG_INV_PITCH = 3'd2,
    REG_PERIOD    = 3'd3,
    REG_LONG      = 3'd4,
    REG_SHORT     = 3'd5,
    REG_SENSOR    = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_COIN  = 2'd1,
    PH_GAP   = 2'd2,
    PH_START = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_ROLL,
    ST_PITCH,
    ST_FINISH,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch input sample, start sqrt
    logic sqrt_step;
    logic roll_init;
    logic pitch_init;
    logic cord_step;
    logic roll_save;
    logic pitch_save;
    logic finish;     // apply capture/evaluation, build result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sqrt_done;
    logic cord_done;
    logic need_angles;
  } dp_sts_t;

  function automatic logic [ZW-1:0] atan_tab(input logic [4:0] i);
    logic [ZW-1:0] r;
    case (i)
      5'd0: r = ZW'(2949120);  5'd1: r = ZW'(1740967);
      5'd2: r = ZW'(919879);   5'd3: r = ZW'(466945);
      5'd4: r = ZW'(234379);   5'd5: r = ZW'(117304);
      5'd6: r = ZW'(58666);    5'd7: r = ZW'(29335);
      5'd8: r = ZW'(14668);    5'd9: r = ZW'(7334);
      5'd10: r = ZW'(3667);    5'd11: r = ZW'(1833);
      5'd12: r = ZW'(917);     5'd13: r = ZW'(458);
      5'd14: r = ZW'(229);     5'd15: r = ZW'(115);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ design/ttfw_ctrl.sv @@
// controller state machine sequencing sqrt, two cordic runs and the result
module ttfw_ctrl import ttfw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SQRT;
      ST_SQRT:   if (sts_i.sqrt_done) state_d = ST_ROLL;
      ST_ROLL:   if (sts_i.cord_done) state_d = ST_PITCH;
      ST_PITCH:  if (sts_i.cord_done) state_d = ST_FINISH;
      ST_FINISH: state_d = ST_OUT;
      ST_OUT:    if (!out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = ~sts_i.sqrt_done;
        cmd_o.roll_init = sts_i.sqrt_done;
      end
      ST_ROLL: begin
        cmd_o.cord_step  = ~sts_i.cord_done;
        cmd_o.roll_save  = sts_i.cord_done;
        cmd_o.pitch_init = sts_i.cord_done;
      end
      ST_PITCH: begin
        cmd_o.cord_step  = ~sts_i.cord_done;
        cmd_o.pitch_save = sts_i.cord_done;
      end
      ST_FINISH: cmd_o.finish = 1'b1;
      ST_OUT:    out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ design/ttfw_dp.sv @@
// datapath: sample registers, sqrt, shared cordic, timing state and direction logic
module ttfw_dp import ttfw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  input  logic [TimeBits-1:0] now_us_i,
  input  logic                pump_pressed_i,
  input  logic                power_pressed_i,
  input  logic signed [15:0]  accel_x_i,
  input  logic signed [15:0]  accel_y_i,
  input  logic signed [15:0]  accel_z_i,
  input  logic [14:0]         thr_i,
  input  logic                inv_roll_i,
  input  logic                inv_pitch_i,
  input  logic [19:0]         period_i,
  input  logic [23:0]         long_i,
  input  logic [23:0]         short_i,
  input  logic                sensor_i,
  output logic [7:0]          res_o
);

  // latched poll
  logic [TimeBits-1:0] now_q;
  logic                pump_q, pwr_q;
  logic signed [15:0]  ax_q, ay_q, az_q;

  // persistent state
  logic                pwr_was_q, nvalid_q;
  logic [TimeBits-1:0] pdown_q, seq_t_q, last_q;
  phase_e              phase_q;
  logic signed [15:0]  nroll_q, npitch_q;
  dir_e                hdir_q, vdir_q;
  logic [7:0]          res_q;

  // sqrt: radicand (ax^2+ay^2)<<16 fits 48 bits; root fits 24
  logic [47:0] rem_q;
  logic [23:0] root_q;
  logic [4:0]  sq_cnt_q;
  logic [49:0] sq_trial;
  logic [49:0] sq_rem_sh;

  // squares of the incoming sample, taken as the poll is latched
  logic [31:0] ax2, ay2;
  logic [31:0] sumsq;
  assign ax2   = unsigned'(32'(accel_x_i * accel_x_i));
  assign ay2   = unsigned'(32'(accel_y_i * accel_y_i));
  assign sumsq = ax2 + ay2;

  // restoring sqrt, one result bit per cycle; shift-in radicand held in sqv_q
  logic [47:0] sqv_q;
  always_comb begin
    sq_rem_sh = {rem_q, sqv_q[47:46]};
    sq_trial  = sq_rem_sh - {24'd0, root_q, 2'b01};
  end

  // cordic
  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [ZW-1:0] cz_q;
  logic [4:0]           ci_q;
  logic signed [CW-1:0] dx, dy;
  assign dx = cy_q >>> ci_q;
  assign dy = cx_q >>> ci_q;

  logic signed [15:0] roll_q, pitch_q;

  // rounding and clamp of cordic angle
  logic signed [ZW-1:0] zr;
  logic signed [ZW-1:0] zang;
  logic signed [15:0]   ang;
  always_comb begin
    zr   = cz_q + ZW'(1 << (TabFrac - AngFrac - 1));
    zang = zr >>> (TabFrac - AngFrac);
    if (zang > ZW'(HalfTurn)) ang = HalfTurn;
    else if (zang < -ZW'(HalfTurn)) ang = -HalfTurn;
    else ang = zang[15:0];
  end

  // cordic pre-rotation
  function automatic void pre_rot(input logic signed [CW-1:0] y, input logic signed [CW-1:0] x,
                                  output logic signed [CW-1:0] xo,
                                  output logic signed [CW-1:0] yo,
                                  output logic signed [ZW-1:0] zo);
    xo = x; yo = y; zo = '0;
    if (x < 0) begin
      if (y >= 0) begin
        xo = y; yo = -x; zo = ZW'(90 <<< TabFrac);
      end else begin
        xo = -y; yo = x; zo = -ZW'(90 <<< TabFrac);
      end
    end
  endfunction

  logic signed [CW-1:0] rx0, ry0, px0, py0;
  logic signed [ZW-1:0] rz0, pz0;
  logic signed [CW-1:0] ay_s, ax_s, az_s, hyp_s;
  always_comb begin
    ay_s  = CW'(ay_q) <<< 8;
    ax_s  = CW'(ax_q) <<< 8;
    az_s  = CW'(az_q) <<< 8;
    hyp_s = CW'(signed'({1'b0, root_q}));
    pre_rot(ay_s, ax_s, rx0, ry0, rz0);
    pre_rot(az_s, hyp_s, px0, py0, pz0);
  end
  logic zero_q;

  // timing
  logic [TimeBits-1:0] el_pwr, el_seq, el_smp;
  assign el_pwr = now_q - pdown_q;
  assign el_seq = now_q - seq_t_q;
  assign el_smp = now_q - last_q;

  logic need;
  assign need = (sensor_i && (el_smp >= TimeBits'(period_i)))
             || (pump_q && !nvalid_q && sensor_i)
             || (!pwr_q && pwr_was_q);

  assign sts_o.sqrt_done   = (sq_cnt_q == 5'd24);
  assign sts_o.cord_done   = (ci_q == 5'(CordSteps));
  assign sts_o.need_angles = need;

  // evaluation combinational
  logic signed [16:0] dr, dp, rw, pw, ar, ap;
  logic signed [16:0] thr_s;
  always_comb begin
    dr = 17'(roll_q) - 17'(nroll_q);
    dp = 17'(pitch_q) - 17'(npitch_q);
    rw = dr; pw = dp;
    if (dr > 17'(HalfTurn)) rw = dr - 17'sd46080;
    else if (dr < -17'(HalfTurn)) rw = dr + 17'sd46080;
    if (dp > 17'(HalfTurn)) pw = dp - 17'sd46080;
    else if (dp < -17'(HalfTurn)) pw = dp + 17'sd46080;
    if (inv_roll_i)  rw = -rw;
    if (inv_pitch_i) pw = -pw;
    ar = (rw < 0) ? -rw : rw;
    ap = (pw < 0) ? -pw : pw;
    thr_s = signed'({2'b00, thr_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwr_was_q <= 1'b0;
      nvalid_q  <= 1'b0;
      pdown_q   <= '0;
      seq_t_q   <= '0;
      last_q    <= '0;
      phase_q   <= PH_IDLE;
      nroll_q   <= '0;
      npitch_q  <= '0;
      hdir_q    <= DIR_NONE;
      vdir_q    <= DIR_NONE;
      res_q     <= '0;
      sq_cnt_q  <= '0;
      ci_q      <= '0;
    end else begin
      if (cmd_i.load) begin
        sq_cnt_q <= '0;
      end else if (cmd_i.sqrt_step) begin
        sq_cnt_q <= sq_cnt_q + 5'd1;
      end
      if (cmd_i.roll_init || cmd_i.pitch_init) begin
        ci_q <= '0;
      end else if (cmd_i.cord_step) begin
        ci_q <= ci_q + 5'd1;
      end
      if (cmd_i.finish) begin
        logic cap, off, coin, start, eval;
        logic [TimeBits-1:0] pd, st, elp;
        phase_e ph;
        dir_e h, v;
        cap = 1'b0; off = 1'b0; coin = 1'b0; start = 1'b0;
        pd = pdown_q; st = seq_t_q; ph = phase_q; h = hdir_q; v = vdir_q;
        if (pump_q && !nvalid_q && sensor_i) cap = 1'b1;
        if (pwr_q && !pwr_was_q) pd = now_q;
        elp = now_q - pd;
        if (pwr_q && elp >= TimeBits'(long_i)) off = 1'b1;
        if (!pwr_q && pwr_was_q && elp < TimeBits'(short_i) && ph == PH_IDLE) begin
          ph = PH_COIN; st = now_q;
          if (sensor_i) cap = 1'b1;
        end
        if (cap) begin
          h = DIR_NONE; v = DIR_NONE;
        end
        case (ph)
          PH_COIN:  begin coin = 1'b1; if (now_q - st > CoinUs) ph = PH_GAP; end
          PH_GAP:   if (now_q - st > GapUs) ph = PH_START;
          PH_START: begin start = 1'b1; if (now_q - st > StartUs) ph = PH_IDLE; end
          default: ;
        endcase
        eval = sensor_i && (el_smp >= TimeBits'(period_i));
        if (eval) begin
          last_q <= now_q;
          h = DIR_NONE; v = DIR_NONE;
          // with fresh capture the relative angle is zero
          if (!(cap || !nvalid_q)) begin
            if (ar >= ap) begin
              if (rw > thr_s) h = DIR_POS;
              else if (rw < -thr_s) h = DIR_NEG;
            end else begin
              if (pw > thr_s) v = DIR_POS;
              else if (pw < -thr_s) v = DIR_NEG;
            end
          end
        end
        if (cap || (eval && !nvalid_q)) begin
          nroll_q  <= roll_q;
          npitch_q <= pitch_q;
          nvalid_q <= 1'b1;
        end
        pwr_was_q <= pwr_q;
        pdown_q   <= pd;
        seq_t_q   <= st;
        phase_q   <= ph;
        hdir_q    <= h;
        vdir_q    <= v;
        res_q     <= {off, start, coin, pump_q, v == DIR_NEG, v == DIR_POS,
                      h == DIR_POS, h == DIR_NEG};
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q  <= now_us_i;
      pump_q <= pump_pressed_i;
      pwr_q  <= power_pressed_i;
      ax_q   <= accel_x_i;
      ay_q   <= accel_y_i;
      az_q   <= accel_z_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      if (!sq_trial[49]) begin
        rem_q  <= sq_trial[47:0];
        root_q <= {root_q[22:0], 1'b1};
      end else begin
        rem_q  <= sq_rem_sh[47:0];
        root_q <= {root_q[22:0], 1'b0};
      end
    end
    if (cmd_i.load) begin
      sqv_q <= {sumsq, 16'd0};
    end else if (cmd_i.sqrt_step) begin
      sqv_q <= {sqv_q[45:0], 2'b00};
    end
    if (cmd_i.roll_init) begin
      cx_q <= rx0; cy_q <= ry0; cz_q <= rz0;
      zero_q <= (ax_q == 0) && (ay_q == 0);
    end else if (cmd_i.pitch_init) begin
      cx_q <= px0; cy_q <= py0; cz_q <= pz0;
      zero_q <= (az_q == 0) && (root_q == 0);
    end else if (cmd_i.cord_step) begin
      if (cy_q > 0) begin
        cx_q <= cx_q + dx; cy_q <= cy_q - dy; cz_q <= cz_q + signed'(atan_tab(ci_q));
      end else begin
        cx_q <= cx_q - dx; cy_q <= cy_q + dy; cz_q <= cz_q - signed'(atan_tab(ci_q));
      end
    end
    if (cmd_i.roll_save)  roll_q  <= zero_q ? '0 : ang;
    if (cmd_i.pitch_save) pitch_q <= zero_q ? '0 : ang;
  end

  assign res_o = res_q;

endmodule

@@ design/tilt_to_four_way_controls_top.sv @@
// top level of the tilt to four-way controls block
//
//  channel | direction | handshake         | payload
//  poll    | in        | in_valid/in_stall | now_us, buttons, accel x/y/z
//  result  | out       | out_valid/stall   | go_*, fire, coin, start_res, power_off
//  config  | in        | cfg_valid/ready   | cfg_index, cfg_data
//
// after the poll is taken the result is built in order: the bit-serial square root
// (24 result bits), the roll and pitch cordic runs on one shared rotator
// (16 iterations each, then save), and a finish step that applies the result
// polls are taken one at a time; the next one is accepted once the result has gone
// stalls on the result side hold the result register and block new polls
// reset clears all timing, sequence, neutral and direction state and loads register defaults
module tilt_to_four_way_controls_top import ttfw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [47:0]        now_us_i,
  input  logic               pump_pressed_i,
  input  logic               power_pressed_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               go_left_o,
  output logic               go_right_o,
  output logic               go_up_o,
  output logic               go_down_o,
  output logic               fire_o,
  output logic               coin_o,
  output logic               start_res_o,
  output logic               power_off_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);

  // configuration registers
  logic [14:0] thr_q;
  logic        inv_roll_q, inv_pitch_q, sensor_q;
  logic [19:0] period_q;
  logic [23:0] long_q, short_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= 15'd1280;
      inv_roll_q  <= 1'b1;
      inv_pitch_q <= 1'b1;
      period_q    <= 20'd16000;
      long_q      <= 24'd1000000;
      short_q     <= 24'd400000;
      sensor_q    <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_THRESHOLD: thr_q       <= cfg_data_i[14:0];
        REG_INV_ROLL:  inv_roll_q  <= cfg_data_i[0];
        REG_INV_PITCH: inv_pitch_q <= cfg_data_i[0];
        REG_PERIOD:    period_q    <= cfg_data_i[19:0];
        REG_LONG:      long_q      <= cfg_data_i;
        REG_SHORT:     short_q     <= cfg_data_i;
        REG_SENSOR:    sensor_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [7:0] res;

  ttfw_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  ttfw_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .now_us_i, .pump_pressed_i, .power_pressed_i, .accel_x_i, .accel_y_i, .accel_z_i,
    .thr_i(thr_q), .inv_roll_i(inv_roll_q), .inv_pitch_i(inv_pitch_q),
    .period_i(period_q), .long_i(long_q), .short_i(short_q), .sensor_i(sensor_q),
    .res_o(res)
  );

  assign go_left_o   = res[0];
  assign go_right_o  = res[1];
  assign go_up_o     = res[2];
  assign go_down_o   = res[3];
  assign fire_o      = res[4];
  assign coin_o      = res[5];
  assign start_res_o = res[6];
  assign power_off_o = res[7];

  // a transaction in never coincides with a result waiting
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("poll accepted while result pending");

  // never both horizontal directions
  a_h_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(go_left_o && go_right_o)) else $error("left and right together");

  // only one axis may move
  a_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (go_left_o || go_right_o) |-> !(go_up_o || go_down_o))
    else $error("both axes active");

  // coin and start phases are exclusive
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(coin_o && start_res_o)) else $error("coin and start together");

endmodule
